// ----- rtl/core/rfae_pkg.sv -----
// Shared types, range limits and threshold tables for the rumble frequency and amplitude
// encoder. The tables are built at elaboration from exact integer power comparisons.
// Depends on nothing; every core module refers to it by scoped names.
package rfae_pkg;

  localparam int FREQ_W  = 17;
  localparam int AMP_W   = 17;
  localparam int THR_W   = 18;
  localparam int FCODE_W = 8;
  localparam int ACODE_W = 7;
  localparam int STEPS   = 8;

  localparam logic [FREQ_W-1:0] FREQ_MIN = 17'd2616;
  localparam logic [FREQ_W-1:0] FREQ_MAX = 17'd80164;
  localparam logic [AMP_W-1:0]  AMP_MAX  = 17'd65536;
  localparam logic [AMP_W-1:0]  AMP_ZERO = 17'd524;
  localparam logic [AMP_W-1:0]  SEG1_MAX = 17'd7372;
  localparam logic [AMP_W-1:0]  SEG2_MAX = 17'd14744;

  localparam logic [FCODE_W-1:0] HF_BASE  = 8'h60;
  localparam logic [FCODE_W-1:0] LF_BASE  = 8'h40;
  localparam logic [FCODE_W-1:0] LF_LIMIT = 8'hC0;
  localparam logic [7:0]         B3_MARK  = 8'h40;
  localparam int                 AMP_CAP  = 100;

  localparam logic [THR_W-1:0] THR_NEVER = 18'h20000;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FREQ = 2'd1,
    ST_AMP  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    SEG_ZERO = 2'd0,
    SEG_LOW  = 2'd1,
    SEG_MID  = 2'd2,
    SEG_HIGH = 2'd3
  } seg_t;

  typedef struct packed {
    logic [FREQ_W-1:0]  freq;
    logic [AMP_W-1:0]   amp;
    seg_t               seg;
    status_t            status;
    logic [FCODE_W-1:0] fcode;
    logic [ACODE_W-1:0] acode;
  } item_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] byte3;
    logic [7:0] byte2;
    logic [7:0] byte1;
    logic [7:0] byte0;
  } result_t;

  // Wide enough for (5*q)^64 and for 18^64 shifted by the largest exponent used.
  localparam int BIG_W = 1280;
  typedef logic [BIG_W-1:0] big_t;

  typedef logic [255:0][THR_W-1:0] freq_tab_t;
  typedef logic [127:0][THR_W-1:0] amp_tab_t;

  // Raises x to the power 2^nlog by repeated squaring.
  function automatic big_t pow_pow2(input big_t x, input int nlog);
    big_t r;
    r = x;
    for (int i = 0; i < 6; i++) begin
      if (i < nlog) r = r * r;
    end
    return r;
  endfunction

  // Smallest input value v for which (scale*v)^(2^nlog) >= rhs; THR_NEVER if none fits.
  function automatic logic [THR_W-1:0] first_meet(input int scale, input int nlog,
                                                  input big_t rhs);
    logic [THR_W-1:0] x;
    logic [THR_W-1:0] t;
    big_t             lhs;
    x = '0;
    for (int b = FREQ_W - 1; b >= 0; b--) begin
      t   = x | (THR_W'(1) << b);
      lhs = pow_pow2(big_t'(t) * big_t'(scale), nlog);
      if (lhs < rhs) x = t;
    end
    return x + THR_W'(1);
  endfunction

  // Entry c is the lowest frequency word whose code is c or more.
  function automatic freq_tab_t build_freq_tab();
    freq_tab_t tab;
    big_t      base;
    base = pow_pow2(big_t'(5), 6);
    for (int c = 0; c < 256; c++) begin
      if (c == 0) tab[c] = '0;
      else        tab[c] = first_meet(1, 6, base << (2 * c + 447));
    end
    return tab;
  endfunction

  // Entry m is the lowest amplitude word in a segment whose code is m or more.
  function automatic amp_tab_t build_amp_tab(input int nlog, input int k0);
    amp_tab_t tab;
    big_t     base;
    base = pow_pow2(big_t'(18), nlog);
    for (int m = 0; m < 128; m++) begin
      if (m == 0)            tab[m] = '0;
      else if (m > AMP_CAP)  tab[m] = THR_NEVER;
      else                   tab[m] = first_meet(5, nlog, base << (2 * m + k0));
    end
    return tab;
  endfunction

  localparam freq_tab_t FREQ_THR = build_freq_tab();
  localparam amp_tab_t  AMP_THR_LOW  = build_amp_tab(3, 57);
  localparam amp_tab_t  AMP_THR_MID  = build_amp_tab(5, 321);
  localparam amp_tab_t  AMP_THR_HIGH = build_amp_tab(6, 705);

  // One binary search step: tries to set bit pos of both codes. The amplitude code
  // has one bit fewer, so the top position refines the frequency code only.
  function automatic item_t search_step(input item_t it, input logic [2:0] pos);
    item_t              r;
    logic [FCODE_W-1:0] fcand;
    logic [ACODE_W-1:0] acand;
    logic [THR_W-1:0]   athr;
    r     = it;
    fcand = it.fcode | (FCODE_W'(1) << pos);
    if ({1'b0, it.freq} >= FREQ_THR[fcand]) r.fcode = fcand;
    acand = it.acode | (ACODE_W'(1) << pos);
    case (it.seg)
      SEG_LOW:  athr = AMP_THR_LOW[acand];
      SEG_MID:  athr = AMP_THR_MID[acand];
      SEG_HIGH: athr = AMP_THR_HIGH[acand];
      default:  athr = THR_NEVER;
    endcase
    if (pos != 3'd7 && {1'b0, it.amp} >= athr) r.acode = acand;
    return r;
  endfunction

endpackage

// ----- rtl/core/rfae_front.sv -----
// Input stage of the encoder: range checks and amplitude segment selection.
// Depends on rfae_pkg.
module rfae_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          up_valid,
  output logic                          up_ready,
  input  logic [rfae_pkg::FREQ_W-1:0]   up_freq,
  input  logic [rfae_pkg::AMP_W-1:0]    up_amp,
  output logic                          dn_valid,
  input  logic                          dn_ready,
  output rfae_pkg::item_t               dn_item
);

  logic            valid_r;
  rfae_pkg::item_t item_r;
  rfae_pkg::item_t item_nxt;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_item  = item_r;

  always_comb begin
    item_nxt.freq  = up_freq;
    item_nxt.amp   = up_amp;
    item_nxt.fcode = '0;
    item_nxt.acode = '0;
    // A bad frequency takes precedence over a bad amplitude.
    if (up_freq < rfae_pkg::FREQ_MIN || up_freq > rfae_pkg::FREQ_MAX) begin
      item_nxt.status = rfae_pkg::ST_FREQ;
    end else if (up_amp > rfae_pkg::AMP_MAX) begin
      item_nxt.status = rfae_pkg::ST_AMP;
    end else begin
      item_nxt.status = rfae_pkg::ST_OK;
    end
    if (up_amp <= rfae_pkg::AMP_ZERO) begin
      item_nxt.seg = rfae_pkg::SEG_ZERO;
    end else if (up_amp <= rfae_pkg::SEG1_MAX) begin
      item_nxt.seg = rfae_pkg::SEG_LOW;
    end else if (up_amp <= rfae_pkg::SEG2_MAX) begin
      item_nxt.seg = rfae_pkg::SEG_MID;
    end else begin
      item_nxt.seg = rfae_pkg::SEG_HIGH;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      item_r <= item_nxt;
    end
  end

endmodule

// ----- rtl/core/rfae_search.sv -----
// Eight-stage binary search of the frequency and amplitude threshold tables.
// Depends on rfae_pkg for the item type, the tables and the step function.
module rfae_search (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            up_valid,
  output logic            up_ready,
  input  rfae_pkg::item_t up_item,
  output logic            dn_valid,
  input  logic            dn_ready,
  output rfae_pkg::item_t dn_item
);

  localparam int N = rfae_pkg::STEPS;

  logic            valid_r [N];
  rfae_pkg::item_t item_r  [N];
  logic            rdy     [N];

  assign up_ready = rdy[0];
  assign dn_valid = valid_r[N-1];
  assign dn_item  = item_r[N-1];

  for (genvar g = 0; g < N; g++) begin : g_stage
    logic            in_valid;
    rfae_pkg::item_t in_item;
    rfae_pkg::item_t item_nxt;

    if (g == 0) begin : g_first
      assign in_valid = up_valid;
      assign in_item  = up_item;
    end else begin : g_rest
      assign in_valid = valid_r[g-1];
      assign in_item  = item_r[g-1];
    end

    if (g == N - 1) begin : g_last
      assign rdy[g] = !valid_r[g] || dn_ready;
    end else begin : g_mid
      assign rdy[g] = !valid_r[g] || rdy[g+1];
    end

    // Stage g decides bit (N-1-g) of the codes, most significant first.
    assign item_nxt = rfae_pkg::search_step(in_item, 3'(N - 1 - g));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[g] <= 1'b0;
      end else if (rdy[g]) begin
        valid_r[g] <= in_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[g] && in_valid) begin
        item_r[g] <= item_nxt;
      end
    end
  end

endmodule

// ----- rtl/core/rfae_pack.sv -----
// Output stage: derives the band codes and packs the four command bytes.
// Depends on rfae_pkg.
module rfae_pack (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  output logic              up_ready,
  input  rfae_pkg::item_t   up_item,
  output logic              dn_valid,
  input  logic              dn_ready,
  output rfae_pkg::result_t dn_result
);

  logic              valid_r;
  rfae_pkg::result_t res_r;
  rfae_pkg::result_t res_nxt;
  logic [7:0]        hf;
  logic [7:0]        lf;
  logic [6:0]        amp;

  assign up_ready  = !valid_r || dn_ready;
  assign dn_valid  = valid_r;
  assign dn_result = res_r;

  always_comb begin
    amp = up_item.acode;
    hf  = (up_item.fcode > rfae_pkg::HF_BASE) ? up_item.fcode - rfae_pkg::HF_BASE : 8'd0;
    // The low-band code wraps modulo 256 below its base, as the command format expects.
    lf  = (up_item.fcode < rfae_pkg::LF_LIMIT) ? up_item.fcode - rfae_pkg::LF_BASE : 8'd0;
    res_nxt.status = up_item.status;
    if (up_item.status == rfae_pkg::ST_OK) begin
      res_nxt.byte0 = {hf[5:0], 2'b00};
      res_nxt.byte1 = {amp, 1'b0} | {6'd0, hf[7:6]};
      res_nxt.byte2 = {amp[0], 7'd0} | lf;
      res_nxt.byte3 = rfae_pkg::B3_MARK | {2'b00, amp[6:1]};
    end else begin
      res_nxt.byte0 = '0;
      res_nxt.byte1 = '0;
      res_nxt.byte2 = '0;
      res_nxt.byte3 = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      res_r <= res_nxt;
    end
  end

endmodule

// ----- rtl/core/rumble_frequency_amplitude_encoder.sv -----
// Top level of the rumble frequency and amplitude encoder.
// Depends on rfae_pkg, rfae_front, rfae_search and rfae_pack.
//
// Usage:
// Each transfer on the input stream carries a requested actuator frequency
// (unsigned Q11.6 hertz) and amplitude (Q1.16, 65536 means 1.0). For each one
// the block sends exactly one transfer on the output stream holding four
// command bytes and a status code. Status 1 flags a frequency outside
// 40.875..1252.5625 Hz, status 2 an amplitude above 1.0; in both cases the four
// bytes are zero, and the frequency check wins when both apply.
// The frequency code is found by an eight-step binary search over a table of
// exact thresholds, and the amplitude code by a seven-step search over one of
// three segment tables, one bit of each code per stage. The pipeline is ten
// register stages deep: input check, eight search steps and byte packing, and
// each item passes through them in that order before out_tvalid rises. One
// transfer is taken per cycle unless the pipeline is full and stalled.
// Every stage holds its item while the next one is full and stalled, so a
// stalled receiver backs the pipeline up without loss or duplication, and
// in_tready falls only once all ten stages are occupied.
// Synchronous reset empties all stages; no tables need filling after reset.
module rumble_frequency_amplitude_encoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // Fields from bit 0: frequency_q6[16:0], amplitude_q16[33:17], zero [39:34].
  input  logic [39:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // Fields from bit 0: byte0[7:0], byte1[15:8], byte2[23:16], byte3[31:24],
  // status[33:32], zero [39:34].
  output logic [39:0] out_tdata
);

  logic              f2s_valid;
  logic              f2s_ready;
  rfae_pkg::item_t   f2s_item;
  logic              s2p_valid;
  logic              s2p_ready;
  rfae_pkg::item_t   s2p_item;
  rfae_pkg::result_t result;

  // Range checks and segment choice.
  rfae_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_tvalid),
    .up_ready (in_tready),
    .up_freq  (in_tdata[16:0]),
    .up_amp   (in_tdata[33:17]),
    .dn_valid (f2s_valid),
    .dn_ready (f2s_ready),
    .dn_item  (f2s_item)
  );

  // Pipelined table search, one code bit per stage.
  rfae_search u_search (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (f2s_valid),
    .up_ready (f2s_ready),
    .up_item  (f2s_item),
    .dn_valid (s2p_valid),
    .dn_ready (s2p_ready),
    .dn_item  (s2p_item)
  );

  // Band codes and command bytes; its register is the output register.
  rfae_pack u_pack (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (s2p_valid),
    .up_ready  (s2p_ready),
    .up_item   (s2p_item),
    .dn_valid  (out_tvalid),
    .dn_ready  (out_tready),
    .dn_result (result)
  );

  assign out_tdata = {6'd0, result.status, result.byte3, result.byte2,
                      result.byte1, result.byte0};

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for rumble_frequency_amplitude_encoder.
// Depends on rfae_pkg (status codes) and the encoder top level; checks each command exactly.
module tb;

  // Range limits and code bases, kept here so that the prediction does not lean
  // on the constants that the design itself uses.
  localparam logic [16:0] FREQ_LO   = 17'd2616;
  localparam logic [16:0] FREQ_HI   = 17'd80164;
  localparam logic [16:0] AMP_ONE   = 17'd65536;
  localparam logic [16:0] AMP_FLOOR = 17'd524;
  localparam logic [16:0] AMP_SEG1  = 17'd7372;
  localparam logic [16:0] AMP_SEG2  = 17'd14744;
  localparam int          HIGH_BASE = 'h60;
  localparam int          LOW_BASE  = 'h40;
  localparam int          LOW_STOP  = 'hC0;
  localparam logic [7:0]  B3_FLAG   = 8'h40;
  localparam int          AMP_SAT   = 100;

  localparam int RANDOM_CMDS  = 2000;
  localparam int FILL_CMDS    = 40;
  localparam int HOLD_CYCLES  = 48;
  localparam int DRAIN_CYCLES = 30;
  localparam int CYCLE_LIMIT  = 300000;

  typedef logic [1279:0] wide_t;

  typedef struct packed {
    rfae_pkg::status_t status;
    logic [7:0]        byte3;
    logic [7:0]        byte2;
    logic [7:0]        byte1;
    logic [7:0]        byte0;
  } command_t;

  typedef struct packed {
    logic [16:0] freq;
    logic [16:0] amp;
    logic        typed;
    command_t    cmd;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;

  command_t    pending_cmds[$];
  command_t    offered_cmd;
  stim_row_t   stim_rows[$];
  int          error_count = 0;
  int          cycle_count = 0;
  logic        hold_req = 1'b0;

  always #2 clk = ~clk;

  rumble_frequency_amplitude_encoder u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // x raised to the power 2^nlog, by repeated squaring.
  function automatic wide_t raise_pow2(input wide_t x, input int nlog);
    wide_t r;
    r = x;
    for (int i = 0; i < nlog; i++) r = r * r;
    return r;
  endfunction

  function automatic int bit_length(input wide_t v);
    for (int i = 1279; i >= 0; i--) begin
      if (v[i]) return i + 1;
    end
    return 0;
  endfunction

  // floor(2^nlog * log2(num/den)) for num > den > 0, decided exactly on integers:
  // the answer is the largest k with den^(2^nlog) * 2^k <= num^(2^nlog).
  function automatic int scaled_log2_floor(input int unsigned num, input int unsigned den,
                                           input int nlog);
    wide_t a;
    wide_t b;
    int    d;
    a = raise_pow2(wide_t'(num), nlog);
    b = raise_pow2(wide_t'(den), nlog);
    d = bit_length(a) - bit_length(b);
    if ((b << d) <= a) return d;
    return d - 1;
  endfunction

  // round(32*log2(f/10)) with f = word/64; log2(word/5) is 7 more than log2(f/10).
  function automatic int freq_code_of(input logic [16:0] f);
    int v;
    v = scaled_log2_floor(f, 5, 6) - 447;
    if (v < 0) v = 0;
    return v / 2;
  endfunction

  // Piecewise logarithmic amplitude code. Each segment rounds k*(log2 x + c) with
  // x = 5q/(18*65536); the exact floor of 2k*log2(5q/18) minus an offset does it.
  function automatic int amp_code_of(input logic [16:0] q);
    int nlog;
    int offset;
    int v;
    if (q <= AMP_FLOOR) return 0;
    if (q <= AMP_SEG1) begin
      nlog = 3; offset = 56;
    end else if (q <= AMP_SEG2) begin
      nlog = 5; offset = 320;
    end else begin
      nlog = 6; offset = 704;
    end
    v = scaled_log2_floor(5 * q, 18, nlog) - offset + 1;
    if (v < 0) v = 0;
    v = v / 2 - 1;
    if (v < 0) v = 0;
    if (v > AMP_SAT) v = AMP_SAT;
    return v;
  endfunction

  function automatic command_t predict_command(input logic [16:0] f, input logic [16:0] q);
    command_t   c;
    int         code;
    logic [7:0] high_band;
    logic [7:0] low_band;
    logic [7:0] amp;
    c = '0;
    c.status = rfae_pkg::ST_OK;
    if (f < FREQ_LO || f > FREQ_HI) begin
      c.status = rfae_pkg::ST_FREQ;
    end else if (q > AMP_ONE) begin
      c.status = rfae_pkg::ST_AMP;
    end else begin
      code      = freq_code_of(f);
      high_band = (code > HIGH_BASE) ? 8'(code - HIGH_BASE) : 8'd0;
      low_band  = (code < LOW_STOP) ? 8'(code - LOW_BASE) : 8'd0;
      amp       = 8'(amp_code_of(q));
      c.byte0   = high_band << 2;
      c.byte1   = (amp << 1) | (high_band >> 6);
      c.byte2   = {amp[0], 7'd0} | low_band;
      c.byte3   = B3_FLAG | (amp >> 1);
    end
    return c;
  endfunction

  // Directed rows: errors carry their expected command typed in, the rest are predicted.
  function automatic stim_row_t error_row(input logic [16:0] f, input logic [16:0] q,
                                          input rfae_pkg::status_t st);
    stim_row_t r;
    r            = '0;
    r.freq       = f;
    r.amp        = q;
    r.typed      = 1'b1;
    r.cmd.status = st;
    return r;
  endfunction

  function automatic stim_row_t predicted_row(input logic [16:0] f, input logic [16:0] q);
    stim_row_t r;
    r       = '0;
    r.freq  = f;
    r.amp   = q;
    r.typed = 1'b0;
    return r;
  endfunction

  // Offers one command at a falling edge and holds it until the block takes it.
  task automatic send_command(input logic [16:0] f, input logic [16:0] q,
                              input logic typed, input command_t want);
    in_tdata    = {6'd0, q, f};
    in_tvalid   = 1'b1;
    offered_cmd = typed ? want : predict_command(f, q);
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic idle_for(input int n);
    in_tvalid = 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid = 1'b0;
    while (pending_cmds.size() != 0) @(negedge clk);
  endtask

  // Mostly legal frequencies, with the band edges and the full word range mixed in.
  function automatic logic [16:0] random_freq();
    int r;
    r = $urandom_range(0, 99);
    if (r < 78) return 17'($urandom_range(FREQ_LO, FREQ_HI));
    if (r < 90) return 17'($urandom_range(0, 131071));
    case ($urandom_range(0, 8))
      0: return FREQ_LO - 17'd1;
      1: return FREQ_LO;
      2: return FREQ_HI;
      3: return FREQ_HI + 17'd1;
      4: return 17'd5119 + 17'($urandom_range(0, 2));
      5: return 17'd40959 + 17'($urandom_range(0, 2));
      6: return 17'd131071;
      7: return 17'd0;
      default: return 17'($urandom_range(FREQ_LO, FREQ_LO + 200));
    endcase
  endfunction

  // Amplitudes spread over all three log segments, the zero floor and overrange.
  function automatic logic [16:0] random_amp();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 17'($urandom_range(0, AMP_ONE));
    if (r < 75) return 17'($urandom_range(0, AMP_SEG2 + 100));
    if (r < 82) return 17'($urandom_range(AMP_FLOOR - 20, AMP_FLOOR + 20));
    if (r < 92) return 17'($urandom_range(0, 131071));
    case ($urandom_range(0, 5))
      0: return AMP_ONE;
      1: return AMP_ONE + 17'd1;
      2: return AMP_SEG1 + 17'($urandom_range(0, 1));
      3: return AMP_SEG2 + 17'($urandom_range(0, 1));
      4: return 17'd131071;
      default: return AMP_ONE - 17'($urandom_range(0, 50));
    endcase
  endfunction

  // Result checker and expectation store. Outputs are compared first, then the
  // transfer taken on the input side at this edge queues its prediction.
  always @(posedge clk) begin
    command_t got;
    command_t exp_cmd;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.byte0  = out_tdata[7:0];
        got.byte1  = out_tdata[15:8];
        got.byte2  = out_tdata[23:16];
        got.byte3  = out_tdata[31:24];
        got.status = rfae_pkg::status_t'(out_tdata[33:32]);
        if (pending_cmds.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result transfer, actual bytes %h %h %h %h status %0d",
                   $time, got.byte0, got.byte1, got.byte2, got.byte3, got.status);
        end else begin
          exp_cmd = pending_cmds.pop_front();
          if (got.byte0 !== exp_cmd.byte0 || got.byte1 !== exp_cmd.byte1 ||
              got.byte2 !== exp_cmd.byte2 || got.byte3 !== exp_cmd.byte3 ||
              got.status !== exp_cmd.status) begin
            error_count++;
            $display("%0t: mismatch, expected %h %h %h %h st %0d, actual %h %h %h %h st %0d",
                     $time, exp_cmd.byte0, exp_cmd.byte1, exp_cmd.byte2, exp_cmd.byte3,
                     exp_cmd.status, got.byte0, got.byte1, got.byte2, got.byte3, got.status);
          end
        end
      end
      if (in_tvalid && in_tready) pending_cmds.push_back(offered_cmd);
    end
  end

  // Receiver. It switches between stall patterns of random length, and on request
  // holds off completely for a fixed stretch so that the pipeline backs up.
  initial begin
    int mode;
    int mode_left;
    int hold_left;
    int phase;
    out_tready = 1'b0;
    mode       = 0;
    mode_left  = 0;
    hold_left  = 0;
    phase      = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_tready = 1'b0;
        hold_left--;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 120);
        end
        mode_left--;
        phase++;
        case (mode)
          0: out_tready = 1'b1;
          1: out_tready = 1'($urandom_range(0, 1));
          2: out_tready = ($urandom_range(0, 7) != 0);
          default: out_tready = (phase % 3 == 0);
        endcase
      end
    end
  end

  // Watchdog on the whole run.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("rumble_frequency_amplitude_encoder test failed");
    $finish;
  end

  initial begin
    int burst_left;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    offered_cmd = '0;
    rst_n       = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part: range limits, the priority of the frequency check, the band
    // edges at codes 0x60 and 0xC0, and every amplitude segment boundary.
    stim_rows.push_back(error_row(17'd0, 17'd0, rfae_pkg::ST_FREQ));
    stim_rows.push_back(error_row(FREQ_LO - 17'd1, 17'd1000, rfae_pkg::ST_FREQ));
    stim_rows.push_back(error_row(FREQ_HI + 17'd1, AMP_ONE, rfae_pkg::ST_FREQ));
    stim_rows.push_back(error_row(17'd131071, 17'd131071, rfae_pkg::ST_FREQ));
    stim_rows.push_back(error_row(FREQ_LO, AMP_ONE + 17'd1, rfae_pkg::ST_AMP));
    stim_rows.push_back(error_row(FREQ_HI, 17'd131071, rfae_pkg::ST_AMP));
    stim_rows.push_back(error_row(17'd40000, AMP_ONE + 17'd1, rfae_pkg::ST_AMP));
    stim_rows.push_back(predicted_row(FREQ_LO, 17'd0));
    stim_rows.push_back(predicted_row(FREQ_HI, AMP_ONE));
    stim_rows.push_back(predicted_row(FREQ_LO, AMP_FLOOR));
    stim_rows.push_back(predicted_row(17'd5120, AMP_FLOOR + 17'd1));
    stim_rows.push_back(predicted_row(17'd5119, AMP_SEG1));
    stim_rows.push_back(predicted_row(17'd5121, AMP_SEG1 + 17'd1));
    stim_rows.push_back(predicted_row(17'd40960, AMP_SEG2));
    stim_rows.push_back(predicted_row(17'd40959, AMP_SEG2 + 17'd1));
    stim_rows.push_back(predicted_row(17'd40961, AMP_ONE - 17'd1));
    stim_rows.push_back(predicted_row(17'd10000, AMP_ONE));
    stim_rows.push_back(predicted_row(FREQ_HI, 17'd1));
    stim_rows.push_back(predicted_row(17'd65535, 17'd32768));
    stim_rows.push_back(predicted_row(17'd65536, 17'd98304 - 17'd32768));
    stim_rows.push_back(predicted_row(FREQ_LO + 17'd1, 17'd131));
    stim_rows.push_back(predicted_row(17'd20000, 17'd3000));

    foreach (stim_rows[i]) begin
      send_command(stim_rows[i].freq, stim_rows[i].amp, stim_rows[i].typed,
                   stim_rows[i].cmd);
      idle_for($urandom_range(0, 2));
    end

    // The sender waits for every result, then the receiver holds off while
    // commands keep coming back to back, so the block fills and stalls its input.
    wait_drained();
    hold_req = 1'b1;
    for (int i = 0; i < FILL_CMDS; i++) send_command(random_freq(), random_amp(), 1'b0, '0);

    burst_left = 0;
    for (int i = 0; i < RANDOM_CMDS; i++) begin
      if (burst_left == 0) begin
        if ($urandom_range(0, 7) == 0) begin
          burst_left = $urandom_range(60, 150);
        end else begin
          burst_left = $urandom_range(1, 25);
          if ($urandom_range(0, 3) != 0) idle_for($urandom_range(1, 8));
        end
      end
      burst_left--;
      if (i == RANDOM_CMDS / 2) wait_drained();
      send_command(random_freq(), random_amp(), 1'b0, '0);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("rumble_frequency_amplitude_encoder test passed");
    end else begin
      $display("rumble_frequency_amplitude_encoder test failed");
    end
    $finish;
  end

endmodule
